// ===== rtl/core/alu32_pkg.sv =====
// Package with the shared opcodes and types of the 32-bit ALU.
`timescale 1ns / 1ps
package alu32_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 4;
  localparam int unsigned ShW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_AND = 4'd2,
    OP_OR  = 4'd3,
    OP_XOR = 4'd4,
    OP_SLL = 4'd5,
    OP_SRL = 4'd6,
    OP_SLT = 4'd7,
    OP_MUL = 4'd8,
    OP_DIV = 4'd9,
    OP_INC = 4'd10,
    OP_DEC = 4'd11,
    OP_NOT = 4'd12,
    OP_EQ  = 4'd13,
    OP_NP0 = 4'd14,
    OP_NP1 = 4'd15
  } alu_op_e;

  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } alu_cls_e;

  typedef struct packed {
    alu_op_e          op;
    alu_cls_e         cls;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic             cin;
  } alu_cmd_t;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic             cout;
    logic             ovf;
  } alu_res_t;

endpackage

// ===== rtl/core/alu_32bit_with_flags.sv =====
// Logic and add results go straight to the output register; divide is bit-serial.
// Throughput: one word per cycle unless stalled; multiply and divide hold the back end.
// A queue of QueueDepth words lets the front keep accepting while the back works.
// Reset is asynchronous, active low; it empties the queue and drops any pending result.
`timescale 1ns / 1ps
module alu_32bit_with_flags
  import alu32_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OpW-1:0]   operation_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  input  logic             carry_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] result_o,
  output logic             carry_out_o,
  output logic             overflow_o,
  output logic             zero_o
);

  alu_cmd_t cmd;
  logic     cmd_valid, cmd_pop;

  alu32_front #(.Depth(QueueDepth)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .carry_in_i  (carry_in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  alu32_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .carry_out_o (carry_out_o),
    .overflow_o  (overflow_o),
    .zero_o      (zero_o)
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (zero_o == (result_o == '0))) else $error("zero flag mismatch");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o))
    else $error("stalled result changed");

endmodule

// ===== rtl/core/alu32_front.sv =====
// Front end: accepts words, classifies the opcode and pushes commands into a queue.
`timescale 1ns / 1ps
module alu32_front
  import alu32_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OpW-1:0]   operation_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  input  logic             carry_in_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output alu_cmd_t         cmd_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  alu_cmd_t        mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]     cnt_q, cnt_d;
  logic            push;
  alu_cmd_t        cmd;

  always_comb begin
    cmd.op  = alu_op_e'(operation_i);
    cmd.a   = operand_a_i;
    cmd.b   = operand_b_i;
    cmd.cin = carry_in_i;
    unique case (cmd.op)
      OP_MUL:  cmd.cls = CLS_MUL;
      OP_DIV:  cmd.cls = CLS_DIV;
      default: cmd.cls = CLS_SIMPLE;
    endcase
  end

  assign in_stall_o  = (cnt_q == (AW+1)'(Depth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_d = (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (AW+1)'(push) - (AW+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/alu32_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module alu32_div
  import alu32_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic             busy_o,
  output logic [DataW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(DataW);

  logic [DataW-1:0] quo_q, quo_d, div_q, div_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  assign trial  = {rem_q, quo_q[DataW-1]};
  assign diff   = trial - {1'b0, div_q};
  assign busy_o = busy_q;
  assign quo_o  = quo_q;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = a_i;
      div_d  = b_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DataW]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DataW-1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

endmodule

// ===== rtl/core/alu32_back.sv =====
// Back end: executes commands and holds the result in an output register.
`timescale 1ns / 1ps
module alu32_back
  import alu32_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  input  alu_cmd_t         cmd_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] result_o,
  output logic             carry_out_o,
  output logic             overflow_o,
  output logic             zero_o
);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_MUL  = 3'b010,
    ST_DIV  = 3'b100
  } back_st_e;

  back_st_e         st_q, st_d;
  alu_res_t         res_q, res_d, simple;
  logic             val_q, val_d;
  logic [DataW-1:0] mul_q;
  logic             div_start, div_busy;
  logic [DataW-1:0] div_quo;
  logic             div_zero_q, div_zero_d;
  logic             slot_free;
  logic [DataW:0]   sum;
  logic [DataW-1:0] bsel;

  alu32_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (cmd_i.a),
    .b_i     (cmd_i.b),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign bsel = (cmd_i.op == OP_SUB) ? ~cmd_i.b : cmd_i.b;

  always_comb begin
    sum = {1'b0, cmd_i.a} + {1'b0, bsel}
        + {{DataW{1'b0}}, (cmd_i.op == OP_SUB) ? ~cmd_i.cin : cmd_i.cin};
    simple = '0;
    unique case (cmd_i.op)
      OP_ADD: begin
        simple.res  = sum[DataW-1:0];
        simple.cout = sum[DataW];
        simple.ovf  = (cmd_i.a[DataW-1] == cmd_i.b[DataW-1])
                   && (sum[DataW-1] != cmd_i.a[DataW-1]);
      end
      OP_SUB: begin
        simple.res  = sum[DataW-1:0];
        simple.cout = ~sum[DataW];
        simple.ovf  = (cmd_i.a[DataW-1] != cmd_i.b[DataW-1])
                   && (sum[DataW-1] != cmd_i.a[DataW-1]);
      end
      OP_AND: simple.res = cmd_i.a & cmd_i.b;
      OP_OR:  simple.res = cmd_i.a | cmd_i.b;
      OP_XOR: simple.res = cmd_i.a ^ cmd_i.b;
      OP_SLL: simple.res = cmd_i.a << cmd_i.b[ShW-1:0];
      OP_SRL: simple.res = cmd_i.a >> cmd_i.b[ShW-1:0];
      OP_SLT: simple.res = DataW'(cmd_i.a < cmd_i.b);
      OP_INC: simple.res = cmd_i.a + 1'b1;
      OP_DEC: simple.res = cmd_i.a - 1'b1;
      OP_NOT: simple.res = ~cmd_i.a;
      OP_EQ:  simple.res = DataW'(cmd_i.a == cmd_i.b);
      default: simple = '0;
    endcase
  end

  assign slot_free = !val_q || !out_stall_i;

  always_comb begin
    st_d       = st_q;
    res_d      = res_q;
    val_d      = val_q && out_stall_i;
    cmd_pop_o  = 1'b0;
    div_start  = 1'b0;
    div_zero_d = div_zero_q;
    unique case (st_q)
      ST_RUN: begin
        if (cmd_valid_i && slot_free) begin
          unique case (cmd_i.cls)
            CLS_MUL: begin
              st_d = ST_MUL;
            end
            CLS_DIV: begin
              st_d       = ST_DIV;
              div_start  = 1'b1;
              div_zero_d = (cmd_i.b == '0);
            end
            default: begin
              cmd_pop_o = 1'b1;
              res_d     = simple;
              val_d     = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (slot_free) begin
          cmd_pop_o = 1'b1;
          res_d     = '{res: mul_q, cout: 1'b0, ovf: 1'b0};
          val_d     = 1'b1;
          st_d      = ST_RUN;
        end
      end
      ST_DIV: begin
        if (!div_busy && slot_free) begin
          cmd_pop_o = 1'b1;
          res_d     = '{res: div_zero_q ? '1 : div_quo, cout: 1'b0, ovf: 1'b0};
          val_d     = 1'b1;
          st_d      = ST_RUN;
        end
      end
      default: st_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q      <= cmd_i.a * cmd_i.b;
    res_q      <= res_d;
    div_zero_q <= div_zero_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_RUN;
      val_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      val_q <= val_d;
    end
  end

  assign out_valid_o = val_q;
  assign result_o    = res_q.res;
  assign carry_out_o = res_q.cout;
  assign overflow_o  = res_q.ovf;
  assign zero_o      = (res_q.res == '0);

endmodule

// ===== dv/alu_32bit_with_flags_test.sv =====
// Self-checking testbench for the 32-bit ALU with flags: directed and random operations.
`timescale 1ns / 1ps
module alu_32bit_with_flags_test;
  import alu32_pkg::*;

  typedef struct {
    logic [DataW-1:0] res;
    logic             cout;
    logic             ovf;
    logic             zero;
  } alu_word_t;

  int unsigned error_count = 0;

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  class alu_scoreboard;
    alu_word_t pending_q[$];

    function alu_word_t compute(alu_op_e op, logic [DataW-1:0] a, logic [DataW-1:0] b,
                                logic cin);
      alu_word_t w;
      logic [DataW:0] wide;
      w.res = '0;
      w.cout = 1'b0;
      w.ovf = 1'b0;
      case (op)
        OP_ADD: begin
          wide = {1'b0, a} + {1'b0, b} + cin;
          w.res = wide[DataW-1:0];
          w.cout = wide[DataW];
          w.ovf = (a[DataW-1] == b[DataW-1]) && (w.res[DataW-1] != a[DataW-1]);
        end
        OP_SUB: begin
          w.res = a - b - cin;
          w.cout = ({1'b0, a} < ({1'b0, b} + cin));
          w.ovf = (a[DataW-1] != b[DataW-1]) && (w.res[DataW-1] != a[DataW-1]);
        end
        OP_AND: w.res = a & b;
        OP_OR:  w.res = a | b;
        OP_XOR: w.res = a ^ b;
        OP_SLL: w.res = a << b[ShW-1:0];
        OP_SRL: w.res = a >> b[ShW-1:0];
        OP_SLT: w.res = (a < b) ? 1 : 0;
        OP_MUL: w.res = a * b;
        OP_DIV: w.res = (b != 0) ? a / b : '1;
        OP_INC: w.res = a + 1;
        OP_DEC: w.res = a - 1;
        OP_NOT: w.res = ~a;
        OP_EQ:  w.res = (a == b) ? 1 : 0;
        default: w.res = '0;
      endcase
      w.zero = (w.res == '0);
      return w;
    endfunction

    function void note_input(alu_op_e op, logic [DataW-1:0] a, logic [DataW-1:0] b,
                             logic cin);
      pending_q.push_back(compute(op, a, b, cin));
    endfunction

    task check_result(logic [DataW-1:0] res, logic cout, logic ovf, logic zero);
      alu_word_t w;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected word", res, '0);
        return;
      end
      w = pending_q.pop_front();
      if (res !== w.res) report_mismatch("result", res, w.res);
      if (cout !== w.cout) report_mismatch("carry_out", DataW'(cout), DataW'(w.cout));
      if (ovf !== w.ovf) report_mismatch("overflow", DataW'(ovf), DataW'(w.ovf));
      if (zero !== w.zero) report_mismatch("zero", DataW'(zero), DataW'(w.zero));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [OpW-1:0]   operation_i = '0;
  logic [DataW-1:0] operand_a_i = '0;
  logic [DataW-1:0] operand_b_i = '0;
  logic             carry_in_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [DataW-1:0] result_o;
  logic             carry_out_o;
  logic             overflow_o;
  logic             zero_o;

  alu_32bit_with_flags DUT (.*);

  alu_scoreboard alu_sb = new();
  bit no_idle = 1'b0;
  longint unsigned cycle_count = 0;
  localparam longint unsigned CycleLimit = 600000;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      alu_sb.check_result(result_o, carry_out_o, overflow_o, zero_o);
  end

  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_word(input alu_op_e op, input logic [DataW-1:0] a,
                           input logic [DataW-1:0] b, input logic cin);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    carry_in_i <= cin;
    do @(posedge clk_i); while (in_stall_o);
    alu_sb.note_input(op, a, b, cin);
    @(negedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_word(OP_ADD, '1, 32'd1, 1'b0);
    send_word(OP_ADD, 32'h7FFF_FFFF, 32'd0, 1'b1);
    send_word(OP_ADD, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_word(OP_SUB, 32'd0, 32'd0, 1'b1);
    send_word(OP_SUB, 32'h8000_0000, 32'd1, 1'b0);
    send_word(OP_SUB, 32'd5, 32'd5, 1'b0);
    send_word(OP_AND, '1, 32'hA5A5_5A5A, 1'b1);
    send_word(OP_OR, 32'd0, 32'd0, 1'b0);
    send_word(OP_XOR, '1, '1, 1'b0);
    send_word(OP_SLL, '1, 32'hFFFF_FFFF, 1'b0);
    send_word(OP_SLL, 32'd1, 32'h0000_0020, 1'b0);
    send_word(OP_SRL, 32'h8000_0000, 32'd31, 1'b0);
    send_word(OP_SLT, 32'd0, '1, 1'b0);
    send_word(OP_SLT, '1, 32'd0, 1'b0);
    send_word(OP_MUL, '1, '1, 1'b0);
    send_word(OP_DIV, 32'd100, 32'd0, 1'b0);
    send_word(OP_DIV, '1, 32'd7, 1'b0);
    send_word(OP_INC, '1, 32'd0, 1'b1);
    send_word(OP_DEC, 32'd0, 32'd0, 1'b0);
    send_word(OP_NOT, '1, 32'd0, 1'b0);
    send_word(OP_EQ, 32'h1234_5678, 32'h1234_5678, 1'b0);
    send_word(OP_NP0, '1, '1, 1'b1);
    send_word(OP_NP1, 32'd3, 32'd4, 1'b0);

    in_valid_i <= 1'b0;
    while (alu_sb.pending_q.size() != 0) @(negedge clk_i);

    for (int i = 0; i < 1700; i++) begin
      if (i == 1400) no_idle = 1'b1;
      a = pick_operand();
      b = pick_operand();
      send_word(alu_op_e'($urandom_range(0, 15)), a, b, 1'($urandom_range(0, 1)));
    end
    in_valid_i <= 1'b0;

    while (alu_sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (error_count == 0 && alu_sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
